FILE: sv/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants for the trial-division factorizer
// Field widths, result limits, status codes and controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

    // Default datapath width of the number being factored
    localparam int NUMBER_WIDTH_DEF   = 24;
    // Fixed widths of the port fields
    localparam int NUMBER_FIELD_WIDTH = 24;
    localparam int FACTOR_WIDTH       = 24;
    localparam int STATUS_WIDTH       = 2;
    // At most this many results per input; the last one is always marked
    localparam int MAX_RESULTS        = 23;
    localparam int COUNT_WIDTH        = $clog2(MAX_RESULTS);

    // Result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK   = 2'd0,  // factor is valid
        STAT_ONE  = 2'd1,  // input was one, no factors
        STAT_ZERO = 2'd2   // input was zero, not factorable
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

endpackage

`default_nettype wire

FILE: sv/tdf_divider.sv
// ----------------------------------------------------------------------------
// tdf_divider: bit-serial restoring divider
// Shifts the dividend in one bit per cycle; quotient and remainder are ready
// when the one-cycle done pulse flags the end of the division.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_divider #(
    parameter int NUMBER_WIDTH = tdf_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [NUMBER_WIDTH-1:0] i_dividend,
    input  wire logic [NUMBER_WIDTH-1:0] i_divisor,
    output logic                         o_done,
    output logic [NUMBER_WIDTH-1:0]      o_quot,
    output logic [NUMBER_WIDTH-1:0]      o_rem
);
    import tdf_pkg::*;

    localparam int W      = NUMBER_WIDTH;
    localparam int STEP_W = $clog2(W + 1);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [W-1:0]      r_quo;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_div;

    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;

    // One restoring step: bring down the next dividend bit, try to subtract
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = ~diff[W];

    // Control: run flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == STEP_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= STEP_W'(W);
        end else if (r_run) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    // Controller never restarts a division in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("divider restarted while running");

    // Done only closes a running division
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run) && !r_run)
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

FILE: sv/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Emits the prime factors of each number in ascending order, repeats
// included, the last one marked; one and zero give a single status result.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                  | Handshake
//  ---------+------------------------------------------+------------------------
//  command  | start, busy, i_number                    | transfer when start & !busy
//  result   | o_valid, o_factor, o_last_factor,        | transfer when o_valid
//           | o_status                                 | (one cycle, no stall)
//
//  Each trial divisor takes one pass of the bit-serial divider, as does each
//  factor found; a prime near 2^24 needs about 4096 trials.
//  Inputs zero and one are answered straight from idle, without the divider.
//  Results come one per divider pass; the receiver cannot stall them.
//  Synchronous reset clears the controller; no memory to sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
    parameter int NUMBER_WIDTH = tdf_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [tdf_pkg::NUMBER_FIELD_WIDTH-1:0] i_number,
    output logic                                     o_valid,
    output logic [tdf_pkg::FACTOR_WIDTH-1:0]         o_factor,
    output logic                                     o_last_factor,
    output logic [tdf_pkg::STATUS_WIDTH-1:0]         o_status
);
    import tdf_pkg::*;

    localparam int W = NUMBER_WIDTH;

    t_state                 r_state,  n_state;
    logic [W-1:0]           r_q,      n_q;
    logic [W-1:0]           r_d,      n_d;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic                   r_valid,  n_valid;
    logic [FACTOR_WIDTH-1:0] r_factor, n_factor;
    logic                   r_last,   n_last;
    t_status                r_status, n_status;

    logic                   div_start;
    logic                   div_done;
    logic [W-1:0]           div_quot;
    logic [W-1:0]           div_rem;
    logic [W-1:0]           in_q;

    assign in_q = W'(i_number);

    // Shared bit-serial divider: q / d per trial
    tdf_divider #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_q),
        .i_divisor  (n_d),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Next state and result selection
    always_comb begin
        n_state   = r_state;
        n_q       = r_q;
        n_d       = r_d;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_factor  = r_factor;
        n_last    = r_last;
        n_status  = r_status;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (in_q == '0) begin
                        n_valid  = 1'b1;
                        n_factor = '0;
                        n_last   = 1'b1;
                        n_status = STAT_ZERO;
                    end else if (in_q == W'(1)) begin
                        n_valid  = 1'b1;
                        n_factor = '0;
                        n_last   = 1'b1;
                        n_status = STAT_ONE;
                    end else begin
                        n_q       = in_q;
                        n_d       = W'(2);
                        n_count   = '0;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        // d divides q: emit d, keep d for repeated factors
                        n_valid  = 1'b1;
                        n_factor = FACTOR_WIDTH'(r_d);
                        n_status = STAT_OK;
                        n_last   = (div_quot == W'(1)) ||
                                   (r_count == COUNT_WIDTH'(MAX_RESULTS - 1));
                        n_count  = r_count + 1'b1;
                        n_q      = div_quot;
                        if (n_last) begin
                            n_state = S_IDLE;
                        end else begin
                            div_start = 1'b1;
                        end
                    end else if (div_quot < r_d) begin
                        // d*d > q: the remaining quotient is prime
                        n_valid  = 1'b1;
                        n_factor = FACTOR_WIDTH'(r_q);
                        n_status = STAT_OK;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_d       = r_d + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_d      <= n_d;
        r_count  <= n_count;
        r_factor <= n_factor;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_factor      = r_factor;
    assign o_last_factor = r_last;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    // Status results carry no factor and close the item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> o_last_factor && (o_factor == '0))
        else $error("status result not marked last or factor nonzero");

    // The final result of an item frees the command port
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_factor |-> !busy)
        else $error("busy after last result");

    // A non-final result means the search goes on
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_factor |-> busy)
        else $error("idle after a non-final result");

    // An accepted command either answers at once or starts work
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || (o_valid && o_last_factor))
        else $error("accepted command produced neither work nor result");
`endif

endmodule

`default_nettype wire

FILE: bench/trial_division_factorizer_test.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer_test: self-checking bench for the factorizer
// Issues numbers on the start/busy command port. Each accepted transfer is
// factored in the bench by trial division into a queue of expected factor
// records. Every o_valid strobe is checked field by field against the oldest
// record. Directed corner numbers come first, then random numbers over three
// sender idle profiles. Most random numbers are built from small factors, so
// that a factor list stays cheap to compute in the block.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tdf_pkg::*;

    localparam int NUM_W = 24;
    localparam logic [NUMBER_FIELD_WIDTH-1:0] ALL_ONES = 24'hFFFFFF;
    // The slowest item is a prime near 2^24; the limit covers about 100 such
    // items several times over.
    localparam int CYCLE_LIMIT = 50_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 27;

    typedef struct {
        logic [FACTOR_WIDTH-1:0] factor;
        logic                    last_factor;
        t_status                 status;
    } t_factor_rec;

    // Factor ledger: expected factor records per accepted number
    class factor_ledger;
        t_factor_rec expected_factors[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Factor one accepted number and queue the records it should produce
        function void note_number(logic [NUMBER_FIELD_WIDTH-1:0] number);
            longint unsigned q;
            longint unsigned d;
            longint unsigned f;
            int              count;
            bit              found;
            t_factor_rec     rec;
            q = longint'(number) & ((64'd1 << NUM_W) - 64'd1);
            if (q == 0) begin
                rec.factor = '0;
                rec.last_factor = 1'b1;
                rec.status = STAT_ZERO;
                expected_factors.push_back(rec);
                return;
            end
            if (q == 1) begin
                rec.factor = '0;
                rec.last_factor = 1'b1;
                rec.status = STAT_ONE;
                expected_factors.push_back(rec);
                return;
            end
            d = 2;
            count = 0;
            while (q != 1 && count < MAX_RESULTS) begin
                f = q;
                found = 1'b0;
                // factors come out ascending, so the search resumes at d
                while (d * d <= q && !found) begin
                    if (q % d == 0) begin
                        f = d;
                        found = 1'b1;
                    end else begin
                        d++;
                    end
                end
                q = q / f;
                rec.factor = f[FACTOR_WIDTH-1:0];
                rec.last_factor = (q == 1) || (count == MAX_RESULTS - 1);
                rec.status = STAT_OK;
                expected_factors.push_back(rec);
                count++;
            end
        endfunction

        // Compare one result transfer with the oldest expected record
        function void check_factor(logic [FACTOR_WIDTH-1:0] factor, logic last_factor,
                                   logic [STATUS_WIDTH-1:0] status);
            t_factor_rec rec;
            if (expected_factors.size() == 0) begin
                $error("unexpected result: factor %0d last_factor %0d status %0d",
                       factor, last_factor, status);
                errors++;
                return;
            end
            rec = expected_factors.pop_front();
            if (factor !== rec.factor) begin
                $error("factor: expected %0d, got %0d", rec.factor, factor);
                errors++;
            end
            if (last_factor !== rec.last_factor) begin
                $error("last_factor: expected %0d, got %0d", rec.last_factor, last_factor);
                errors++;
            end
            if (status !== rec.status) begin
                $error("status: expected %0d, got %0d", rec.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_factors.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [NUMBER_FIELD_WIDTH-1:0] i_number = '0;
    logic                          busy;
    logic                          o_valid;
    logic [FACTOR_WIDTH-1:0]       o_factor;
    logic                          o_last_factor;
    logic [STATUS_WIDTH-1:0]       o_status;

    factor_ledger ledger = new();

    trial_division_factorizer #(
        .NUMBER_WIDTH(NUM_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_number(i_number),
        .o_valid(o_valid),
        .o_factor(o_factor),
        .o_last_factor(o_last_factor),
        .o_status(o_status)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitor: note command transfers first, then check result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) ledger.note_number(i_number);
            if (o_valid) ledger.check_factor(o_factor, o_last_factor, o_status);
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Issue one number; idle_pct is the chance per cycle of holding start low
    task automatic send_number(logic [NUMBER_FIELD_WIDTH-1:0] number, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_number <= number;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop issuing and wait until every expected factor has come out, after
    // first letting the monitor note the last transfer
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    // Random numbers: mostly products of small factors, some plain
    // small-width values, a few tiny values and rare full-width ones
    task automatic run_random_phase(int items, int idle_pct);
        longint unsigned n;
        longint unsigned k;
        int              kind;
        int              w;
        bit              full;
        for (int i = 0; i < items; i++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                n = 1;
                full = 1'b0;
                do begin
                    k = ($urandom_range(3) == 0) ? $urandom_range(4000, 2) :
                                                   $urandom_range(60, 2);
                    if (n * k > ALL_ONES) full = 1'b1;
                    else n = n * k;
                end while (!full && $urandom_range(9) != 0);
            end else if (kind < 90) begin
                w = $urandom_range(16, 1);
                n = $urandom & ((32'd1 << w) - 1);
            end else if (kind < 97) begin
                n = $urandom_range(3, 0);
            end else begin
                n = $urandom & ALL_ONES;
            end
            send_number(n[NUMBER_FIELD_WIDTH-1:0], idle_pct);
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, one, small primes and powers, all-ones patterns,
        // the longest factor list and the largest 24-bit prime
        send_number(24'd0, 16);
        send_number(24'd1, 16);
        send_number(24'd2, 16);
        send_number(24'd3, 16);
        send_number(24'd4, 16);
        send_number(24'd6, 0);
        send_number(24'd9, 0);
        send_number(24'd12, 0);
        send_number(24'd49, 0);
        send_number(24'd97, 16);
        send_number(24'd121, 16);
        send_number(ALL_ONES, 16);
        send_number(24'hFFFFFE, 0);
        send_number(24'h800000, 0);
        send_number(24'h7FFFFF, 16);
        send_number(24'hAAAAAA, 16);
        send_number(24'h555555, 0);
        send_number(24'd16777213, 0);
        send_number(24'd1, 0);
        send_number(24'd0, 0);
        drain();

        // Random: sender idling light, heavy, then not at all
        run_random_phase(PHASE_ITEMS, 16);
        run_random_phase(PHASE_ITEMS, 82);
        run_random_phase(PHASE_ITEMS, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
